>>> rtl/core/hxdm_pkg.sv
package hxdm_pkg;

    // CORDIC iteration count and gain-compensated start value in Q30.
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam int OUT_LIMIT = 65535;

    // Arctangent of 2^-i in 2^-32 turn units.
    function automatic logic signed [33:0] atan_turn(input int i);
        logic signed [33:0] t;
        begin
            case (i)
                0: t = 34'sd536870912;
                1: t = 34'sd316933406;
                2: t = 34'sd167458907;
                3: t = 34'sd85004756;
                4: t = 34'sd42667331;
                5: t = 34'sd21354465;
                6: t = 34'sd10679838;
                7: t = 34'sd5340245;
                8: t = 34'sd2670163;
                9: t = 34'sd1335087;
                10: t = 34'sd667544;
                11: t = 34'sd333772;
                12: t = 34'sd166886;
                13: t = 34'sd83443;
                14: t = 34'sd41722;
                15: t = 34'sd20861;
                16: t = 34'sd10430;
                17: t = 34'sd5215;
                18: t = 34'sd2608;
                19: t = 34'sd1304;
                20: t = 34'sd652;
                21: t = 34'sd326;
                22: t = 34'sd163;
                23: t = 34'sd81;
                24: t = 34'sd41;
                25: t = 34'sd20;
                26: t = 34'sd10;
                27: t = 34'sd5;
                28: t = 34'sd3;
                29: t = 34'sd1;
                default: t = 34'sd0;
            endcase
            return t;
        end
    endfunction

    // One CORDIC rotation state.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_t;

endpackage

>>> rtl/core/hxdm_sincos.sv
// Pipelined CORDIC: one micro-rotation per stage, quadrant applied at the end.
module hxdm_sincos
    import hxdm_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ANGLE_BITS-1:0]    angle,
    output logic signed [33:0]       cos_q30,
    output logic signed [33:0]       sin_q30
);

    cordic_t             st_reg   [CORDIC_STEPS+1];
    logic [1:0]          quad_reg [CORDIC_STEPS+1];
    logic signed [33:0]  z0;

    // Offset inside the quadrant scaled to 2^-32 turn units.
    always_comb
    begin
        z0 = '0;
        z0[29:32-ANGLE_BITS] = angle[ANGLE_BITS-3:0];
    end

    always_ff @(posedge clk)
    begin
        st_reg[0]   <= '{x: CORDIC_K, y: '0, z: z0};
        quad_reg[0] <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge clk)
        begin
            if (!st_reg[i].z[33]) begin
                st_reg[i+1].x <= st_reg[i].x - (st_reg[i].y >>> i);
                st_reg[i+1].y <= st_reg[i].y + (st_reg[i].x >>> i);
                st_reg[i+1].z <= st_reg[i].z - atan_turn(i);
            end else begin
                st_reg[i+1].x <= st_reg[i].x + (st_reg[i].y >>> i);
                st_reg[i+1].y <= st_reg[i].y - (st_reg[i].x >>> i);
                st_reg[i+1].z <= st_reg[i].z + atan_turn(i);
            end
            quad_reg[i+1] <= quad_reg[i];
        end
    end

    // Quadrant unfold.
    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            2'd0:
            begin
                cos_q30 = st_reg[CORDIC_STEPS].x;
                sin_q30 = st_reg[CORDIC_STEPS].y;
            end
            2'd1:
            begin
                cos_q30 = -st_reg[CORDIC_STEPS].y;
                sin_q30 = st_reg[CORDIC_STEPS].x;
            end
            2'd2:
            begin
                cos_q30 = -st_reg[CORDIC_STEPS].x;
                sin_q30 = -st_reg[CORDIC_STEPS].y;
            end
            default:
            begin
                cos_q30 = st_reg[CORDIC_STEPS].y;
                sin_q30 = -st_reg[CORDIC_STEPS].x;
            end
        endcase
    end

    logic unused_rst;
    assign unused_rst = rst_n;

endmodule

>>> rtl/core/hxdm_rdiv.sv
// Pipelined restoring divider, one quotient bit per stage, round half away.
// Magnitude of numerator N_BITS wide, divisor D_BITS wide, unsigned.
module hxdm_rdiv #(
    parameter int N_BITS = 48,
    parameter int D_BITS = 34,
    parameter int TAG_BITS = 1
) (
    input  logic                 clk,
    input  logic [N_BITS-1:0]    num,
    input  logic [D_BITS-1:0]    den,
    input  logic                 neg,
    input  logic [TAG_BITS-1:0]  tag_in,
    output logic signed [N_BITS:0] quo,
    output logic [TAG_BITS-1:0]  tag_out
);

    logic [N_BITS-1:0]  q_reg   [N_BITS+1];
    logic [D_BITS:0]    r_reg   [N_BITS+1];
    logic [N_BITS-1:0]  n_reg   [N_BITS+1];
    logic [D_BITS-1:0]  d_reg   [N_BITS+1];
    logic               s_reg   [N_BITS+1];
    logic [TAG_BITS-1:0] t_reg  [N_BITS+1];

    // Add half the divisor before the division.
    always_ff @(posedge clk)
    begin
        n_reg[0] <= num + N_BITS'(den >> 1);
        d_reg[0] <= den;
        s_reg[0] <= neg;
        t_reg[0] <= tag_in;
        q_reg[0] <= '0;
        r_reg[0] <= '0;
    end

    for (genvar i = 0; i < N_BITS; i++) begin : g_bit
        logic [D_BITS+1:0] trial;
        assign trial = {r_reg[i], n_reg[i][N_BITS-1-i]};
        always_ff @(posedge clk)
        begin
            n_reg[i+1] <= n_reg[i];
            d_reg[i+1] <= d_reg[i];
            s_reg[i+1] <= s_reg[i];
            t_reg[i+1] <= t_reg[i];
            if (trial >= {2'b00, d_reg[i]}) begin
                r_reg[i+1] <= (D_BITS+1)'(trial - {2'b00, d_reg[i]});
                q_reg[i+1] <= q_reg[i] | (N_BITS'(1) << (N_BITS-1-i));
            end else begin
                r_reg[i+1] <= (D_BITS+1)'(trial);
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    assign quo = s_reg[N_BITS] ? -$signed({1'b0, q_reg[N_BITS]})
                               : $signed({1'b0, q_reg[N_BITS]});
    assign tag_out = t_reg[N_BITS];

endmodule

>>> rtl/core/holonomic_x_drive_mixer_core.sv
// Channel    | Ports                                          | Handshake
// -----------+------------------------------------------------+-----------------
// command    | magnitude, heading, rotation                   | start, busy
// wheels     | front_left/front_right/back_right/back_left_velocity | done strobe
// config     | cfg_data                                       | cfg_we
//
// One request enters per clock; busy is never raised. The wheel set appears
// with done after the request passes 31 CORDIC stages, 49 boost
// divider stages, three wheel stages, 41 normalize divider stages, then the
// scale product and the saturated output register. Reset clears the valid
// bits and loads the scale register with its default. The receiver cannot
// stall: done pulses for one cycle per request.
module holonomic_x_drive_mixer_core
    import hxdm_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  magnitude,
    input  logic [15:0]         heading,
    input  logic signed [15:0]  rotation,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    output logic                done,
    output logic signed [16:0]  front_left_velocity,
    output logic signed [16:0]  front_right_velocity,
    output logic signed [16:0]  back_right_velocity,
    output logic signed [16:0]  back_left_velocity
);

    localparam int CLAT = CORDIC_STEPS + 1;
    localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);
    localparam int D1N = 48;
    localparam int D2N = 40;
    localparam int D2D = 24;
    localparam logic signed [23:0] ONE = 24'sd1 << FRAC_BITS;

    logic [15:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= 16'd3413;
        else if (cfg_we)
            scale_reg <= cfg_data;
    end

    assign busy = 1'b0;

    // Angle preparation: fold for theta, offset for the wheel angle.
    logic [ANGLE_BITS-1:0] h, r, theta, phi;
    always_comb
    begin
        h = ANGLE_BITS'(heading);
        r = h & (EIGHTH - 1'b1);
        theta = h[ANGLE_BITS-3] ? r : EIGHTH - r;
        phi = h - EIGHTH;
    end

    logic signed [33:0] ct, st_u, ca, sa;
    hxdm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_cs_theta (
        .clk(clk), .rst_n(rst_n), .angle(theta), .cos_q30(ct), .sin_q30(st_u));
    hxdm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_cs_phi (
        .clk(clk), .rst_n(rst_n), .angle(phi), .cos_q30(ca), .sin_q30(sa));

    // Valid and side data aligned with the CORDIC.
    logic               v1_reg   [CLAT+1];
    logic signed [15:0] mag_reg  [CLAT+1];
    logic signed [15:0] rot_reg  [CLAT+1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i <= CLAT; i++) v1_reg[i] <= 1'b0;
        else begin
            v1_reg[0] <= start;
            for (int i = 1; i <= CLAT; i++) v1_reg[i] <= v1_reg[i-1];
        end
    end
    always_ff @(posedge clk)
    begin
        mag_reg[0] <= magnitude;
        rot_reg[0] <= rotation;
        for (int i = 1; i <= CLAT; i++) begin
            mag_reg[i] <= mag_reg[i-1];
            rot_reg[i] <= rot_reg[i-1];
        end
    end

    // Boost division: magnitude * 2^30 / cos(theta); tag carries valid, rotation and the wheel trig.
    localparam int T1 = 1 + 16 + 68;
    logic [D1N-1:0] n1;
    logic [T1-1:0] t1_in, t1_out;
    logic signed [D1N:0] mfin;
    assign n1 = D1N'(mag_reg[CLAT-1] < 0 ? -34'(mag_reg[CLAT-1]) : 34'(mag_reg[CLAT-1])) << 30;
    assign t1_in = {v1_reg[CLAT-1], rot_reg[CLAT-1], ca, sa};
    hxdm_rdiv #(.N_BITS(D1N), .D_BITS(34), .TAG_BITS(T1)) u_div_boost (
        .clk(clk), .num(n1), .den(ct), .neg(mag_reg[CLAT-1] < 0),
        .tag_in(t1_in), .quo(mfin), .tag_out(t1_out));

    logic div1_v;
    logic signed [15:0] rot1;
    logic signed [33:0] ca1, sa1;
    assign {div1_v, rot1, ca1, sa1} = t1_out;

    // The boosted magnitude stays below 2^17 and the trig values below 2^31.
    logic signed [17:0] mfin_s;
    logic signed [31:0] ca_s, sa_s;
    assign mfin_s = 18'(mfin);
    assign ca_s   = 32'(ca1);
    assign sa_s   = 32'(sa1);

    // Product stage registered (18 by 32 bit signed), then rounded shift by 30.
    logic signed [49:0] pa_reg, pb_reg;
    logic signed [15:0] rot_p_reg;
    logic pv_reg;
    always_ff @(posedge clk)
    begin
        pa_reg <= 50'(mfin_s) * 50'(ca_s);
        pb_reg <= 50'(mfin_s) * 50'(sa_s);
        rot_p_reg <= rot1;
    end

    function automatic logic signed [23:0] rsh30(input logic signed [49:0] p);
        logic [49:0] a;
        logic [49:0] q;
        begin
            a = p[49] ? 50'(-p) : 50'(p);
            q = (a + 50'd536870912) >> 30;
            return p[49] ? -24'(q) : 24'(q);
        end
    endfunction

    logic signed [23:0] wa_reg, wb_reg;
    logic signed [15:0] rot_w_reg;
    always_ff @(posedge clk)
    begin
        wa_reg <= rsh30(pa_reg) + 24'(rot_p_reg);
        wb_reg <= -rsh30(pb_reg) + 24'(rot_p_reg);
        rot_w_reg <= rot_p_reg;
    end

    // Wheels C and D, and the largest magnitude, at least one.
    logic signed [23:0] wc, wd;
    logic [23:0] aa, ab, ac, ad, mx;
    always_comb
    begin
        wc = -(wa_reg - 24'(rot_w_reg)) + 24'(rot_w_reg);
        wd = -(wb_reg - 24'(rot_w_reg)) + 24'(rot_w_reg);
        aa = wa_reg[23] ? -wa_reg : wa_reg;
        ab = wb_reg[23] ? -wb_reg : wb_reg;
        ac = wc[23] ? -wc : wc;
        ad = wd[23] ? -wd : wd;
        mx = 24'(ONE);
        if (aa > mx) mx = aa;
        if (ab > mx) mx = ab;
        if (ac > mx) mx = ac;
        if (ad > mx) mx = ad;
    end

    logic signed [23:0] w_reg [4];
    logic [23:0] mx_reg;
    always_ff @(posedge clk)
    begin
        w_reg[0] <= wa_reg;
        w_reg[1] <= wb_reg;
        w_reg[2] <= wc;
        w_reg[3] <= wd;
        mx_reg   <= mx;
    end

    // Valid bits through the boost divider and the three wheel stages.
    localparam int PV = D1N + 4;
    logic vp_reg [PV];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < PV; i++) vp_reg[i] <= 1'b0;
        else begin
            vp_reg[0] <= v1_reg[CLAT-1];
            for (int i = 1; i < PV; i++) vp_reg[i] <= vp_reg[i-1];
        end
    end
    assign pv_reg = vp_reg[PV-1];

    // Normalize: four dividers in parallel; dividing by one leaves a wheel unchanged.
    logic signed [D2N:0] nq [4];
    logic [0:0] ntag [4];
    logic signed [23:0] wn [4];
    for (genvar k = 0; k < 4; k++) begin : g_norm
        logic [D2N-1:0] nn;
        assign nn = D2N'(w_reg[k][23] ? -w_reg[k] : w_reg[k]) << FRAC_BITS;
        hxdm_rdiv #(.N_BITS(D2N), .D_BITS(D2D), .TAG_BITS(1)) u_div_norm (
            .clk(clk), .num(nn), .den(mx_reg), .neg(w_reg[k][23]),
            .tag_in(1'b0), .quo(nq[k]), .tag_out(ntag[k]));
        assign wn[k] = 24'(nq[k]);
    end

    localparam int V2 = D2N + 1;
    logic vq_reg [V2];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < V2; i++) vq_reg[i] <= 1'b0;
        else begin
            vq_reg[0] <= pv_reg;
            for (int i = 1; i < V2; i++) vq_reg[i] <= vq_reg[i-1];
        end
    end

    // Scale multiply registered (24 by 17 bit signed), then rounded shift and saturate.
    logic signed [41:0] sp_reg [4];
    logic sv_reg;
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
            sp_reg[k] <= 42'(wn[k]) * 42'($signed({1'b0, scale_reg}));
    end

    function automatic logic signed [16:0] scale_out(input logic signed [41:0] p);
        logic [41:0] a;
        logic [41:0] q;
        begin
            a = p[41] ? 42'(-p) : 42'(p);
            q = (a + (42'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (q > 42'(OUT_LIMIT)) q = 42'(OUT_LIMIT);
            return p[41] ? -17'(q) : 17'(q);
        end
    endfunction

    logic signed [16:0] o_reg [4];
    logic done_reg;
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++) o_reg[k] <= scale_out(sp_reg[k]);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            sv_reg   <= vq_reg[V2-1];
            done_reg <= sv_reg;
        end
    end

    assign done = done_reg;
    assign front_left_velocity  = o_reg[0];
    assign front_right_velocity = o_reg[1];
    assign back_right_velocity  = o_reg[2];
    assign back_left_velocity   = o_reg[3];

    logic unused;
    assign unused = ^{st_u, div1_v, ntag[0], ntag[1], ntag[2], ntag[3]};

    // The output strobe follows the last valid stage in the next cycle.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        $past(sv_reg) |-> done) else $error("done lost");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("busy raised");
    // Saturated outputs never reach the most negative 17-bit code.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (front_left_velocity != 17'h10000 &&
                  front_right_velocity != 17'h10000 &&
                  back_right_velocity != 17'h10000 &&
                  back_left_velocity != 17'h10000))
        else $error("saturation mismatch");

endmodule

>>> dv/holonomic_x_drive_mixer_core_test.sv
`timescale 1ns / 1ps

module holonomic_x_drive_mixer_core_test;

    // One set of wheel commands as the block presents it.
    typedef struct {
        logic signed [16:0] front_left;
        logic signed [16:0] front_right;
        logic signed [16:0] back_right;
        logic signed [16:0] back_left;
    } wheel_set_t;

    // Arctangent of 2^-i in 2^-32 turn units.
    localparam longint ATAN_STEP [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1
    };
    localparam longint ROT_GAIN  = 652032874;
    localparam longint UNIT      = 64'sd1 << 14;
    localparam longint EIGHTH    = 64'sd1 << 13;
    localparam longint SAT_LIMIT = 65535;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 200;

    // Mixer model plus the queue of wheel sets still owed by the block.
    class wheel_scoreboard;
        longint scale;
        wheel_set_t owed[$];
        int errors;
        int checked;

        function new();
            scale = 3413;
            errors = 0;
            checked = 0;
        endfunction

        static function longint round_div(longint n, longint d);
            longint q;
            begin
                if (n < 0)
                    q = -((-n + d / 2) / d);
                else
                    q = (n + d / 2) / d;
                return q;
            end
        endfunction

        // Cosine and sine in Q30 of a 16-bit fraction of a turn.
        static function void cos_sin(input longint ang, output longint c,
                                     output longint s);
            longint a, z, x, y, dx, dy;
            int quad;
            begin
                a = ang & 64'hFFFF;
                quad = int'(a >> 14);
                z = (a & 64'h3FFF) << 16;
                x = ROT_GAIN;
                y = 0;
                for (int i = 0; i < 30; i++)
                begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0)
                    begin
                        x -= dx; y += dy; z -= ATAN_STEP[i];
                    end
                    else
                    begin
                        x += dx; y -= dy; z += ATAN_STEP[i];
                    end
                end
                case (quad & 3)
                    0: begin c = x;  s = y;  end
                    1: begin c = -y; s = x;  end
                    2: begin c = -x; s = -y; end
                    default: begin c = y; s = -x; end
                endcase
            end
        endfunction

        // Note an accepted request and queue the wheel set it must produce.
        function void note_request(logic signed [15:0] mag, logic [15:0] head,
                                   logic signed [15:0] rot);
            longint h, r, theta, ct, st, ca, sa, boosted, peak, v;
            longint w[4];
            wheel_set_t e;
            begin
                h = longint'(head);
                r = h & (EIGHTH - 1);
                theta = ((h >> 13) & 1) ? r : EIGHTH - r;
                cos_sin(theta, ct, st);
                boosted = round_div(longint'(mag) * (64'sd1 << 30), ct);
                cos_sin((h - EIGHTH) & 64'hFFFF, ca, sa);
                w[0] = round_div(boosted * ca, 64'sd1 << 30);
                w[1] = -round_div(boosted * sa, 64'sd1 << 30);
                w[2] = -w[0];
                w[3] = -w[1];
                peak = UNIT;
                for (int k = 0; k < 4; k++)
                begin
                    w[k] += longint'(rot);
                    if ((w[k] < 0 ? -w[k] : w[k]) > peak)
                        peak = w[k] < 0 ? -w[k] : w[k];
                end
                // Normalize, apply the velocity scale and saturate.
                for (int k = 0; k < 4; k++)
                begin
                    v = w[k];
                    if (peak > UNIT)
                        v = round_div(v * UNIT, peak);
                    v = round_div(v * scale, UNIT);
                    if (v > SAT_LIMIT) v = SAT_LIMIT;
                    if (v < -SAT_LIMIT) v = -SAT_LIMIT;
                    w[k] = v;
                end
                e.front_left  = w[0][16:0];
                e.front_right = w[1][16:0];
                e.back_right  = w[2][16:0];
                e.back_left   = w[3][16:0];
                owed.push_back(e);
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        // Compare one delivered wheel set with the oldest owed one.
        task check_wheels(wheel_set_t got);
            wheel_set_t e;
            begin
                checked++;
                if (owed.size() == 0)
                    report("unexpected done", 1, 0);
                else
                begin
                    e = owed.pop_front();
                    if (got.front_left !== e.front_left)
                        report("front_left_velocity", got.front_left, e.front_left);
                    if (got.front_right !== e.front_right)
                        report("front_right_velocity", got.front_right, e.front_right);
                    if (got.back_right !== e.back_right)
                        report("back_right_velocity", got.back_right, e.back_right);
                    if (got.back_left !== e.back_left)
                        report("back_left_velocity", got.back_left, e.back_left);
                end
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] magnitude = '0;
    logic [15:0] heading = '0;
    logic signed [15:0] rotation = '0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic done;
    logic signed [16:0] front_left_velocity;
    logic signed [16:0] front_right_velocity;
    logic signed [16:0] back_right_velocity;
    logic signed [16:0] back_left_velocity;

    wheel_scoreboard sb = new();
    int idle_pct = 0;
    int cycles = 0;
    int sent = 0;

    holonomic_x_drive_mixer_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .magnitude(magnitude),
        .heading(heading),
        .rotation(rotation),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .done(done),
        .front_left_velocity(front_left_velocity),
        .front_right_velocity(front_right_velocity),
        .back_right_velocity(back_right_velocity),
        .back_left_velocity(back_left_velocity)
    );

    always #1 clk = ~clk;

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Results are sampled at the edge that ends their strobe cycle.
    always @(posedge clk)
    begin
        wheel_set_t got;
        if (rst_n && done)
        begin
            got.front_left  = front_left_velocity;
            got.front_right = front_right_velocity;
            got.back_right  = back_right_velocity;
            got.back_left   = back_left_velocity;
            sb.check_wheels(got);
        end
    end

    // Present one request and hold it until it is taken.
    task send_request(logic signed [15:0] mag, logic [15:0] head,
                      logic signed [15:0] rot);
        begin
            start <= 1'b1;
            magnitude <= mag;
            heading <= head;
            rotation <= rot;
            do
                @(posedge clk);
            while (busy);
            sb.note_request(mag, head, rot);
            sent++;
            if ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    endtask

    // Let the pipeline empty out completely.
    task wait_drained();
        begin
            start <= 1'b0;
            while (sb.owed.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task write_scale(logic [15:0] value);
        begin
            wait_drained();
            cfg_we <= 1'b1;
            cfg_data <= value;
            @(posedge clk);
            cfg_we <= 1'b0;
            sb.scale = longint'(value);
        end
    endtask

    // Mostly realistic commands, with some full-range noise.
    task send_random();
        begin
            if ($urandom_range(99) < 70)
                send_request(16'($signed($urandom_range(0, 32768)) - 16384),
                             16'($urandom), 16'($signed($urandom_range(0, 16384)) - 8192));
            else
                send_request(16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        logic [15:0] scales [6];
        int pcts [6];
        scales = '{16'd3413, 16'd0, 16'd65535, 16'd1, 16'd20000, 16'd3413};
        pcts = '{20, 82, 0, 20, 82, 0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, octant edges, wrap and saturation.
        send_request(16'sd0, 16'd0, 16'sd0);
        send_request(16'sd16384, 16'd0, 16'sd0);
        send_request(16'sd16384, 16'd8192, 16'sd0);
        send_request(16'sd16384, 16'd8191, 16'sd0);
        send_request(16'sd16384, 16'd16384, 16'sd0);
        send_request(16'sd16384, 16'd32768, 16'sd0);
        send_request(16'sd16384, 16'd57344, 16'sd0);
        send_request(16'sd16384, 16'd65535, 16'sd0);
        send_request(-16'sd16384, 16'd4096, 16'sd0);
        send_request(16'sh7FFF, 16'd12345, 16'sh7FFF);
        send_request(16'sh8000, 16'd40000, 16'sh8000);
        send_request(16'sh7FFF, 16'd0, 16'sh8000);
        send_request(16'sh8000, 16'hFFFF, 16'sh7FFF);
        send_request(16'sd0, 16'd0, 16'sd16384);
        send_request(16'sd0, 16'd0, -16'sd16384);
        send_request(16'sd8000, 16'd24576, 16'sd4000);
        send_request(16'sd10000, 16'd49152, -16'sd12000);

        for (int p = 0; p < 6; p++)
        begin
            write_scale(scales[p] == 16'd20000 ? 16'($urandom) : scales[p]);
            idle_pct = pcts[p];
            for (int n = 0; n < 300; n++)
            begin
                // Once per phase the sender holds until the block drains.
                if (n == 150)
                    wait_drained();
                send_random();
            end
        end

        wait_drained();
        $display("Sent %0d drive commands over six scale settings, checked %0d wheel sets.",
                 sent, sb.checked);
        $display("Scales covered zero, one, full range and random; sender gaps 0/20/82 percent.");
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
